@@ hw/rtl/sorted_matrix_staircase_search_defines.svh @@
// Assertion macros shared by the staircase search checker
`ifndef SORTED_MATRIX_STAIRCASE_SEARCH_DEFINES_SVH
`define SORTED_MATRIX_STAIRCASE_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sms_pkg.sv @@
// Shared types and constants of the sorted matrix staircase search
`timescale 1ns / 1ps

package sms_pkg;

  // Default matrix bounds
  localparam int MaxRowsDef = 8;
  localparam int MaxColsDef = 8;

  // Field widths
  localparam int PosW   = 3;
  localparam int ValueW = 32;
  localparam int CfgW   = 4;
  localparam int CfgIdxW = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRowsIdx = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgColsIdx = 1'b1;

  // Configuration reset values
  localparam logic [CfgW-1:0] CfgRowsRst = 4'd3;
  localparam logic [CfgW-1:0] CfgColsRst = 4'd3;

  // Action codes
  localparam logic ActionWrite  = 1'b0;
  localparam logic ActionSearch = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StCmp,
    StDone
  } sms_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic start;    // latch key, reset walk position
    logic write;    // store one entry
    logic read;     // fetch entry at walk position
    logic compare;  // compare fetched entry with key and move
    logic publish;  // load result register
  } sms_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_area;  // walk position lies inside the area in use
    logic cmp_eq;   // fetched entry equals key
    logic out_free; // result register can take a new result
  } sms_sts_t;

endpackage

@@ hw/rtl/sms_datapath.sv @@
// Datapath: matrix memory, walk position, compare and result register
`timescale 1ns / 1ps

module sms_datapath #(
  parameter int MAX_ROWS = sms_pkg::MaxRowsDef,
  parameter int MAX_COLS = sms_pkg::MaxColsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sms_pkg::sms_cmd_t            cmd_i,
  output sms_pkg::sms_sts_t            sts_o,
  input  logic [sms_pkg::PosW-1:0]     entry_row_i,
  input  logic [sms_pkg::PosW-1:0]     entry_col_i,
  input  logic [sms_pkg::ValueW-1:0]   entry_value_i,
  input  logic [sms_pkg::ValueW-1:0]   search_key_i,
  input  logic                         cfg_we_i,
  input  logic [sms_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sms_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         res_ready_i,
  output logic                         res_valid_o,
  output logic                         found_o,
  output logic [sms_pkg::PosW-1:0]     found_row_o,
  output logic [sms_pkg::PosW-1:0]     found_col_o
);

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);

  logic [sms_pkg::ValueW-1:0] mem_q [Depth];

  logic [sms_pkg::CfgW-1:0]   rows_cfg_q, cols_cfg_q;
  logic [RW-1:0]              rows_sat;
  logic [CW-1:0]              cols_sat;
  logic [RW-1:0]              r_q, r_d;
  logic [CW-1:0]              c_q, c_d;
  logic [CW-1:0]              c_m1;
  logic                       hit_q, hit_d;
  logic signed [sms_pkg::ValueW-1:0] key_q, rdata_q;
  logic [AW-1:0]              wr_addr, rd_addr;
  logic                       wr_in_range;
  logic                       res_valid_q, res_valid_d;
  logic                       found_q;
  logic [sms_pkg::PosW-1:0]   row_q, col_q;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= sms_pkg::CfgRowsRst;
      cols_cfg_q <= sms_pkg::CfgColsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sms_pkg::CfgRowsIdx: rows_cfg_q <= cfg_data_i;
        sms_pkg::CfgColsIdx: cols_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Saturate the area in use to the matrix bounds
  assign rows_sat = (32'(rows_cfg_q) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(rows_cfg_q);
  assign cols_sat = (32'(cols_cfg_q) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cols_cfg_q);

  // Address computation for writes and walk reads
  assign wr_in_range = (32'(entry_row_i) < MAX_ROWS) && (32'(entry_col_i) < MAX_COLS);
  assign wr_addr     = AW'(entry_row_i) * AW'(MAX_COLS) + AW'(entry_col_i);
  assign c_m1        = c_q - CW'(1);
  assign rd_addr     = AW'(r_q) * AW'(MAX_COLS) + AW'(c_m1);

  // Matrix memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.write && wr_in_range) begin
      mem_q[wr_addr] <= entry_value_i;
    end
    if (cmd_i.read) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Latch the search key
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q <= search_key_i;
    end
  end

  // Walk position and hit flag
  always_comb begin
    r_d   = r_q;
    c_d   = c_q;
    hit_d = hit_q;
    if (cmd_i.start) begin
      r_d   = '0;
      c_d   = cols_sat;
      hit_d = 1'b0;
    end else if (cmd_i.compare) begin
      if (rdata_q == key_q) begin
        hit_d = 1'b1;
      end else if (rdata_q > key_q) begin
        c_d = c_m1;
      end else begin
        r_d = r_q + RW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q   <= '0;
      c_q   <= '0;
      hit_q <= 1'b0;
    end else begin
      r_q   <= r_d;
      c_q   <= c_d;
      hit_q <= hit_d;
    end
  end

  // Result register: load on publish, drop when taken
  always_comb begin
    res_valid_d = res_valid_q;
    if (cmd_i.publish) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      found_q <= hit_q;
      row_q   <= hit_q ? sms_pkg::PosW'(r_q) : '0;
      col_q   <= hit_q ? sms_pkg::PosW'(c_m1) : '0;
    end
  end

  assign sts_o.in_area  = (r_q < rows_sat) && (c_q != '0);
  assign sts_o.cmp_eq   = (rdata_q == key_q);
  assign sts_o.out_free = !res_valid_q || res_ready_i;

  assign res_valid_o = res_valid_q;
  assign found_o     = found_q;
  assign found_row_o = row_q;
  assign found_col_o = col_q;

endmodule

@@ hw/rtl/sms_ctrl.sv @@
// Controller: state machine that sequences writes and search walks
`timescale 1ns / 1ps

module sms_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              action_i,
  input  sms_pkg::sms_sts_t sts_i,
  output sms_pkg::sms_cmd_t cmd_o
);

  sms_pkg::sms_state_e state_q, state_d;
  logic                accept;

  assign accept = in_valid_i && (state_q == sms_pkg::StIdle);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sms_pkg::StIdle: begin
        if (accept && (action_i == sms_pkg::ActionSearch)) begin
          state_d = sms_pkg::StRead;
        end
      end
      sms_pkg::StRead: begin
        state_d = sts_i.in_area ? sms_pkg::StCmp : sms_pkg::StDone;
      end
      sms_pkg::StCmp: begin
        state_d = sts_i.cmp_eq ? sms_pkg::StDone : sms_pkg::StRead;
      end
      sms_pkg::StDone: begin
        if (sts_i.out_free) begin
          state_d = sms_pkg::StIdle;
        end
      end
      default: state_d = sms_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sms_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sms_pkg::StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.write   = accept && (action_i == sms_pkg::ActionWrite);
        cmd_o.start   = accept && (action_i == sms_pkg::ActionSearch);
      end
      sms_pkg::StRead: begin
        cmd_o.read = sts_i.in_area;
      end
      sms_pkg::StCmp: begin
        cmd_o.compare = 1'b1;
      end
      sms_pkg::StDone: begin
        cmd_o.publish = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/sorted_matrix_staircase_search.sv @@
// Top level of the sorted matrix staircase search
// Write: stored when accepted, no result. Search: k compare steps, k <= rows +
// cols - 1, each one memory read and one compare; done follows a compare on a
// hit, a read off the area on a miss; next input is taken the cycle after the
// result loads, held while the result stalls.
// Reset clears control state and sets both area registers to 3; memory is undefined.
`timescale 1ns / 1ps

module sorted_matrix_staircase_search #(
  parameter int MAX_ROWS = sms_pkg::MaxRowsDef,
  parameter int MAX_COLS = sms_pkg::MaxColsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [71:0]                 s_axis_tdata,  // entry_row, entry_col, entry_value,
                                                     // search_key, zero fill
  input  logic                        s_axis_tuser,  // action
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // found_row, found_col, zero fill
  output logic                        m_axis_tuser,  // found
  input  logic                        cfg_we_i,
  input  logic [sms_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sms_pkg::CfgW-1:0]    cfg_data_i
);

  sms_pkg::sms_cmd_t cmd;
  sms_pkg::sms_sts_t sts;
  logic [sms_pkg::PosW-1:0] found_row, found_col;

  sms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .action_i   (s_axis_tuser),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sms_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .entry_row_i   (s_axis_tdata[2:0]),
    .entry_col_i   (s_axis_tdata[5:3]),
    .entry_value_i (s_axis_tdata[37:6]),
    .search_key_i  (s_axis_tdata[69:38]),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .res_ready_i   (m_axis_tready),
    .res_valid_o   (m_axis_tvalid),
    .found_o       (m_axis_tuser),
    .found_row_o   (found_row),
    .found_col_o   (found_col)
  );

  // Pack result fields
  assign m_axis_tdata = {2'b00, found_col, found_row};

endmodule

@@ hw/rtl/sms_checker.sv @@
// Port-level checker for the staircase search, bound to the top level
`timescale 1ns / 1ps
`include "sorted_matrix_staircase_search_defines.svh"

module sms_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [7:0]                  m_axis_tdata,
  input logic                        m_axis_tuser
);

  // Stalled result holds
  `SMS_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // Miss reports a zero position
  `SMS_ASSERT_IMPLY(a_miss_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 8'h00, "miss with nonzero position")

  // Accepted search blocks input while the walk runs
  `SMS_ASSERT_NEXT(a_search_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && (s_axis_tuser == sms_pkg::ActionSearch), !s_axis_tready, "input taken during walk")

  // New result appears only out of a walk
  `SMS_ASSERT_IMPLY(a_res_from_walk, clk_i, rst_ni, $rose(m_axis_tvalid), !$past(s_axis_tready), "result without a search")

endmodule

bind sorted_matrix_staircase_search sms_checker u_sms_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ tb/tb_sorted_matrix_staircase_search.sv @@
// Self-checking testbench of the sorted matrix staircase search block
`timescale 1ns / 1ps

module tb_sorted_matrix_staircase_search;

  localparam int N_ROWS         = sms_pkg::MaxRowsDef;
  localparam int N_COLS         = sms_pkg::MaxColsDef;
  // longest walk plus margin, in cycles
  localparam int WALK_CYCLES    = 2 * (N_ROWS + N_COLS) + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int N_PHASES       = 8;
  localparam int PHASE_ITEMS    = 70;
  localparam int REPORT_MAX     = 10;

  typedef logic signed [sms_pkg::ValueW-1:0] word_t;

  localparam word_t W_MIN = 32'sh8000_0000;
  localparam word_t W_MAX = 32'sh7FFF_FFFF;

  // One search outcome as the block reports it
  typedef struct packed {
    logic                     found;
    logic [sms_pkg::PosW-1:0] row;
    logic [sms_pkg::PosW-1:0] col;
  } hit_t;

  typedef enum logic {RowItem, RowCfg} row_kind_e;

  // One row of the directed stimulus table
  typedef struct packed {
    row_kind_e                   kind;
    logic                        act;
    logic [sms_pkg::PosW-1:0]    row;
    logic [sms_pkg::PosW-1:0]    col;
    word_t                       val;
    word_t                       key;
    logic [sms_pkg::CfgIdxW-1:0] reg_idx;
    logic [sms_pkg::CfgW-1:0]    reg_val;
    logic                        typed;
    hit_t                        exp;
  } dir_row_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [71:0]                 s_axis_tdata;   // entry_row, entry_col, entry_value,
                                               // search_key, zero fill
  logic                        s_axis_tuser;   // action
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [7:0]                  m_axis_tdata;   // found_row, found_col, zero fill
  logic                        m_axis_tuser;   // found
  logic                        cfg_we_i;
  logic [sms_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [sms_pkg::CfgW-1:0]    cfg_data_i;

  // Predictor state: matrix copy and area registers
  word_t                    grid_model [N_ROWS][N_COLS];
  logic [sms_pkg::CfgW-1:0] area_rows;
  logic [sms_pkg::CfgW-1:0] area_cols;

  hit_t pending_hits [$];

  int send_idle_pct;
  int ready_stall_pct;
  int fail_count;
  int n_writes;
  int n_searches;
  int n_hits;
  int n_cfg;
  int idle_cycles;

  sorted_matrix_staircase_search DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Walk from the top-right corner of the area: left on greater, down on smaller
  function automatic hit_t staircase_walk(word_t key);
    int unsigned rows;
    int unsigned cols;
    int unsigned r;
    int unsigned c;
    hit_t res;
    rows = (area_rows > N_ROWS) ? N_ROWS : area_rows;
    cols = (area_cols > N_COLS) ? N_COLS : area_cols;
    r = 0;
    c = cols;
    res = '0;
    while (r < rows && c > 0 && !res.found) begin
      if (grid_model[r][c-1] > key) begin
        c--;
      end else if (grid_model[r][c-1] < key) begin
        r++;
      end else begin
        res.found = 1'b1;
        res.row   = r[sms_pkg::PosW-1:0];
        res.col   = 3'(c - 1);
      end
    end
    return res;
  endfunction

  // Value of some entry inside the area; an empty dimension is widened to the full matrix
  function automatic word_t area_entry();
    int unsigned rows;
    int unsigned cols;
    rows = (area_rows > N_ROWS) ? N_ROWS : area_rows;
    cols = (area_cols > N_COLS) ? N_COLS : area_cols;
    if (rows == 0) rows = N_ROWS;
    if (cols == 0) cols = N_COLS;
    return grid_model[$urandom_range(0, rows - 1)][$urandom_range(0, cols - 1)];
  endfunction

  function automatic void set_pacing(int mode);
    case (mode)
      0: begin
        send_idle_pct = 0;  ready_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 60; ready_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;  ready_stall_pct = 60;
      end
      default: begin
        send_idle_pct = 20; ready_stall_pct = 20;
      end
    endcase
  endfunction

  // Directed table builders
  function automatic dir_row_t t_wr(int r, int c, word_t v);
    dir_row_t e;
    e = '0;
    e.act = sms_pkg::ActionWrite;
    e.row = 3'(r);
    e.col = 3'(c);
    e.val = v;
    e.key = word_t'($urandom());
    return e;
  endfunction

  function automatic dir_row_t t_sr(word_t k);
    dir_row_t e;
    e = '0;
    e.act = sms_pkg::ActionSearch;
    e.row = 3'($urandom());
    e.col = 3'($urandom());
    e.val = word_t'($urandom());
    e.key = k;
    return e;
  endfunction

  function automatic dir_row_t t_sx(word_t k, logic f, int r, int c);
    dir_row_t e;
    e = t_sr(k);
    e.typed     = 1'b1;
    e.exp.found = f;
    e.exp.row   = 3'(r);
    e.exp.col   = 3'(c);
    return e;
  endfunction

  function automatic dir_row_t t_cf(logic [sms_pkg::CfgIdxW-1:0] idx, int v);
    dir_row_t e;
    e = '0;
    e.kind    = RowCfg;
    e.reg_idx = idx;
    e.reg_val = 4'(v);
    return e;
  endfunction

  // Offer one item and record what it should cause once accepted
  task automatic push_item(input logic act, input logic [sms_pkg::PosW-1:0] row,
                           input logic [sms_pkg::PosW-1:0] col, input word_t val,
                           input word_t key, input logic typed, input hit_t exp);
    hit_t want;
    @(negedge clk_i);
    while (chance(send_idle_pct)) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {2'b00, key, val, col, row};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (act == sms_pkg::ActionWrite) begin
      grid_model[row][col] = val;
      n_writes++;
    end else begin
      want = typed ? exp : staircase_walk(key);
      pending_hits.push_back(want);
      n_searches++;
      if (want.found) n_hits++;
    end
  endtask

  // Hold the sender until every search has reported, then let the block drain
  task automatic settle(input int drain);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(negedge clk_i);
    repeat (drain) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [sms_pkg::CfgIdxW-1:0] idx,
                           input logic [sms_pkg::CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sms_pkg::CfgRowsIdx) area_rows = val;
    else area_cols = val;
    n_cfg++;
  endtask

  // Fill all entries with a matrix non-decreasing along rows and columns
  task automatic load_sorted_matrix();
    longint      grid_val [N_ROWS][N_COLS];
    longint      prev;
    int unsigned step_hi;
    int          k;
    int          r;
    int          c;
    bit          rev;
    case ($urandom_range(0, 3))
      0: begin
        grid_val[0][0] = W_MIN;          step_hi = 3;
      end
      1: begin
        grid_val[0][0] = word_t'($urandom()); step_hi = 1000;
      end
      2: begin
        grid_val[0][0] = longint'(W_MAX) - 4000; step_hi = 1000;
      end
      default: begin
        grid_val[0][0] = W_MIN;          step_hi = 1 << 28;
      end
    endcase
    for (r = 0; r < N_ROWS; r++) begin
      for (c = 0; c < N_COLS; c++) begin
        if (r != 0 || c != 0) begin
          if (r == 0) prev = grid_val[r][c-1];
          else if (c == 0) prev = grid_val[r-1][c];
          else prev = (grid_val[r-1][c] > grid_val[r][c-1]) ? grid_val[r-1][c]
                                                            : grid_val[r][c-1];
          grid_val[r][c] = prev + longint'($urandom_range(0, step_hi));
          // clamp at the top keeps the order, with repeats
          if (grid_val[r][c] > W_MAX) grid_val[r][c] = W_MAX;
        end
      end
    end
    rev = $urandom_range(0, 1);
    for (k = 0; k < N_ROWS * N_COLS; k++) begin
      r = (rev ? (N_ROWS * N_COLS - 1 - k) : k) / N_COLS;
      c = (rev ? (N_ROWS * N_COLS - 1 - k) : k) % N_COLS;
      push_item(sms_pkg::ActionWrite, 3'(r), 3'(c), word_t'(grid_val[r][c]),
                word_t'($urandom()), 1'b0, '0);
    end
  endtask

  // Drive ready at random according to the pacing mode
  always @(negedge clk_i) begin
    m_axis_tready <= !chance(ready_stall_pct);
  end

  // Compare each result transaction with the oldest outstanding search
  always @(posedge clk_i) begin : check_results
    hit_t got;
    hit_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.found = m_axis_tuser;
      got.row   = m_axis_tdata[2:0];
      got.col   = m_axis_tdata[5:3];
      if (pending_hits.size() == 0) begin
        if (fail_count < REPORT_MAX)
          $display("%0t: result found=%0b row=%0d col=%0d with no search outstanding",
                   $time, got.found, got.row, got.col);
        fail_count++;
      end else begin
        want = pending_hits.pop_front();
        if (got != want) begin
          if (fail_count < REPORT_MAX)
            $display("%0t: mismatch expected found=%0b row=%0d col=%0d, got found=%0b row=%0d col=%0d",
                     $time, want.found, want.row, want.col, got.found, got.row, got.col);
          fail_count++;
        end
      end
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, pending_hits.size());
        $display("sorted_matrix_staircase_search verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    dir_row_t                 dir_tbl [26];
    logic [sms_pkg::CfgW-1:0] rows_plan [N_PHASES] =
      '{4'd8, 4'd15, 4'd1, 4'd8, 4'd0, 4'd6, 4'd9, 4'd4};
    logic [sms_pkg::CfgW-1:0] cols_plan [N_PHASES] =
      '{4'd8, 4'd15, 4'd8, 4'd1, 4'd4, 4'd0, 4'd3, 4'd4};
    int                       ph;
    int                       i;
    int                       roll;
    word_t                    key;

    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = sms_pkg::ActionWrite;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = sms_pkg::CfgRowsIdx;
    cfg_data_i      = '0;
    area_rows       = sms_pkg::CfgRowsRst;
    area_cols       = sms_pkg::CfgColsRst;
    fail_count      = 0;
    n_writes        = 0;
    n_searches      = 0;
    n_hits          = 0;
    n_cfg           = 0;
    idle_cycles     = 0;
    set_pacing(0);

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // 3x3 area from reset: extremes in the corners, then 1x1, empty and disturbed order
    dir_tbl = '{
      t_wr(0, 0, W_MIN), t_wr(0, 1, -5), t_wr(0, 2, 10),
      t_wr(1, 0, -4),    t_wr(1, 1, 0),  t_wr(1, 2, 20),
      t_wr(2, 0, 7),     t_wr(2, 1, 30), t_wr(2, 2, W_MAX),
      t_sx(10, 1'b1, 0, 2), t_sx(W_MIN, 1'b1, 0, 0), t_sx(W_MAX, 1'b1, 2, 2),
      t_sr(7), t_sr(0), t_sx(W_MAX - 1, 1'b0, 0, 0),
      t_cf(sms_pkg::CfgColsIdx, 1), t_cf(sms_pkg::CfgRowsIdx, 1),
      t_sx(W_MIN, 1'b1, 0, 0), t_sx(10, 1'b0, 0, 0),
      t_cf(sms_pkg::CfgRowsIdx, 0), t_sx(10, 1'b0, 0, 0),
      t_cf(sms_pkg::CfgRowsIdx, 3), t_cf(sms_pkg::CfgColsIdx, 3),
      t_wr(1, 1, 100), t_sx(100, 1'b0, 0, 0), t_sr(-4)
    };

    foreach (dir_tbl[n]) begin
      if (dir_tbl[n].kind == RowCfg) begin
        settle(WALK_CYCLES);
        write_reg(dir_tbl[n].reg_idx, dir_tbl[n].reg_val);
      end else begin
        push_item(dir_tbl[n].act, dir_tbl[n].row, dir_tbl[n].col, dir_tbl[n].val,
                  dir_tbl[n].key, dir_tbl[n].typed, dir_tbl[n].exp);
      end
    end

    rows_plan[N_PHASES-1] = 4'($urandom_range(1, N_ROWS));
    cols_plan[N_PHASES-1] = 4'($urandom_range(1, N_COLS));

    // Random phases: new area and fresh sorted matrix, then mostly searches
    for (ph = 0; ph < N_PHASES; ph++) begin
      settle(WALK_CYCLES);
      set_pacing(ph % 4);
      write_reg(sms_pkg::CfgRowsIdx, rows_plan[ph]);
      write_reg(sms_pkg::CfgColsIdx, cols_plan[ph]);
      load_sorted_matrix();
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 || chance(2)) settle(0);
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          // stray write, may break the ordering
          push_item(sms_pkg::ActionWrite, 3'($urandom()), 3'($urandom()),
                    word_t'($urandom()), word_t'($urandom()), 1'b0, '0);
        end else begin
          if (roll < 55) key = area_entry();
          else if (roll < 72) key = area_entry() + (chance(50) ? 1 : -1);
          else if (roll < 92) key = word_t'($urandom());
          else key = chance(50) ? W_MIN : W_MAX;
          push_item(sms_pkg::ActionSearch, 3'($urandom()), 3'($urandom()),
                    word_t'($urandom()), key, 1'b0, '0);
        end
      end
    end

    settle(WALK_CYCLES);
    $display("Run covered %0d entry writes, %0d searches (%0d expected hits), %0d register writes",
             n_writes, n_searches, n_hits, n_cfg);
    $display("Areas from empty to oversized, sorted and disturbed matrices, four pacing modes");
    if (fail_count == 0) begin
      $display("sorted_matrix_staircase_search verification clean");
    end else begin
      $display("sorted_matrix_staircase_search verification failed");
    end
    $finish;
  end

endmodule
